@@ rtl/core/rrts_pkg.sv @@
// Shared types and constants of the round-robin task scheduler.
// Used by the scheduler top level; depends on nothing.
package rrts_pkg;

   localparam int DEFAULT_SLOT_COUNT = 32;

   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_SLEEP = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE        = 2'd0,
      STATUS_NO_FREE     = 2'd1,
      STATUS_ALREADY     = 2'd2,
      STATUS_NOT_RUNNING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SS_FREE  = 2'd0,
      SS_ALLOC = 2'd1,
      SS_RUN   = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_SCAN = 3'b010,
      FSM_DONE = 3'b100
   } fsm_type;

endpackage

@@ rtl/core/rrts_cell.sv @@
// One storage cell of the scheduler's circulating rows.
// Holds one entry and takes its neighbor's entry when the row shifts; no dependencies.
module rrts_cell #(
   parameter int               WIDTH = 2,
   parameter logic [WIDTH-1:0] INIT  = '0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in_sel;

   assign data_in_sel = shift ? data_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= INIT;
      end else begin
         data_ff <= data_in_sel;
      end
   end

   assign data_out = data_ff;

endmodule

@@ rtl/core/round_robin_task_scheduler.sv @@
// Round-robin task scheduler top level: control sequencer and two rows of cells.
// Depends on rrts_pkg and rrts_cell.
//
// Each item is scanned through the rows and then loaded into the output register,
// and one item is processed at a time: a new item is accepted only once the
// result of the last one has been loaded, and loading waits while an earlier
// result has not been taken. The slot-state row and the run-list row rotate
// once through all SLOT_COUNT cells per item so that every entry passes the
// head cell, where allocation, appends, removal with gap closing and state
// updates happen. The input side is ready again while a finished result still
// waits to be taken. After reset, slot 0 is running alone at position 0 and all
// other slots are free.
module round_robin_task_scheduler #(
   parameter int SLOT_COUNT = rrts_pkg::DEFAULT_SLOT_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rrts_pkg::CMD_W-1:0]    req_command,
   input  logic [rrts_pkg::SLOT_W-1:0]   req_task_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rrts_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrts_pkg::SLOT_W-1:0]   rsp_granted_slot,
   output logic                          rsp_switched,
   output logic [rrts_pkg::SLOT_W-1:0]   rsp_current_slot,
   output logic [rrts_pkg::COUNT_W-1:0]  rsp_running_count
);

   import rrts_pkg::*;

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int MW = (SW > SLOT_W) ? SW : SLOT_W;
   localparam logic [SW-1:0] LAST_IDX   = SW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SLOT_COUNT);

   logic [1:0]    st_q [SLOT_COUNT];
   logic [SW-1:0] ls_q [SLOT_COUNT];
   logic [1:0]    st_tail;
   logic [SW-1:0] ls_tail;
   logic          shift;

   fsm_type             fsm_ff, fsm_in;
   logic [SW-1:0]       idx_ff, idx_in;
   cmd_type             cmd_ff, cmd_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                slot_ok_ff, slot_ok_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SW-1:0]       pos_ff, pos_in;
   logic                found_ff, found_in;
   logic [SW-1:0]       grant_ff, grant_in;
   logic [1:0]          hit_state_ff, hit_state_in;
   logic                removed_ff, removed_in;
   logic [SW-1:0]       rpos_ff, rpos_in;
   logic [SW-1:0]       hp_ff, hp_in;
   logic [SW-1:0]       hp1_ff, hp1_in;
   logic [SW-1:0]       h0_ff, h0_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic                rsp_switched_ff, rsp_switched_in;
   logic [SLOT_W-1:0]   rsp_current_ff, rsp_current_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [CW-1:0] idx_cw;
   logic          in_list;
   logic          slot_hit;
   logic          list_hit;
   logic          alloc_hit;
   logic          load;

   status_type    res_status;
   logic [SW-1:0] res_granted;
   logic          res_switched;
   logic [SW-1:0] res_cur;
   logic [CW-1:0] res_count;
   logic [SW-1:0] res_pos;
   logic          run_ok;

   assign shift = (fsm_ff == FSM_SCAN);

   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      logic [1:0]    st_d;
      logic [SW-1:0] ls_d;

      if (k == SLOT_COUNT - 1) begin : g_tail
         assign st_d = st_tail;
         assign ls_d = ls_tail;
      end else begin : g_body
         assign st_d = st_q[k+1];
         assign ls_d = ls_q[k+1];
      end

      rrts_cell #(
         .WIDTH (2),
         .INIT  ((k == 0) ? 2'(SS_RUN) : 2'(SS_FREE))
      ) u_state_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .data_in  (st_d),
         .data_out (st_q[k])
      );

      rrts_cell #(
         .WIDTH (SW),
         .INIT  ('0)
      ) u_list_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .data_in  (ls_d),
         .data_out (ls_q[k])
      );
   end

   // Head cell logic: the entry at the head moves to the tail, possibly modified.
   always_comb begin
      idx_cw    = CW'(idx_ff);
      in_list   = (idx_cw < count_ff);
      slot_hit  = (MW'(idx_ff) == MW'(slot_ff));
      alloc_hit = (cmd_ff == CMD_ALLOC) && !found_ff && (st_q[0] == SS_FREE);
      list_hit  = (cmd_ff == CMD_SLEEP) && in_list && !removed_ff
                  && (MW'(ls_q[0]) == MW'(slot_ff));

      st_tail = st_q[0];
      if (alloc_hit) begin
         st_tail = SS_ALLOC;
      end
      if (slot_hit && (cmd_ff == CMD_RUN) && (st_q[0] != SS_RUN)
          && (count_ff != FULL_COUNT)) begin
         st_tail = SS_RUN;
      end
      if (slot_hit && (cmd_ff == CMD_SLEEP) && (st_q[0] == SS_RUN)) begin
         st_tail = SS_ALLOC;
      end

      if ((cmd_ff == CMD_RUN) && (idx_cw == count_ff)) begin
         ls_tail = SW'(slot_ff);
      end else if (removed_ff || list_hit) begin
         ls_tail = ls_q[1];
      end else begin
         ls_tail = ls_q[0];
      end
   end

   // Result of the item once the rows have gone round.
   always_comb begin
      res_status   = STATUS_DONE;
      res_granted  = '0;
      res_switched = 1'b0;
      res_count    = count_ff;
      res_pos      = pos_ff;
      res_cur      = (count_ff != '0) ? hp_ff : '0;
      run_ok       = slot_ok_ff && (hit_state_ff != SS_RUN) && (count_ff != FULL_COUNT);

      case (cmd_ff)
         CMD_ALLOC: begin
            if (found_ff) begin
               res_granted = grant_ff;
            end else begin
               res_status = STATUS_NO_FREE;
            end
         end
         CMD_RUN: begin
            if (!slot_ok_ff) begin
               res_status = STATUS_NOT_RUNNING;
            end else if (hit_state_ff == SS_RUN) begin
               res_status = STATUS_ALREADY;
            end
            if (run_ok) begin
               res_count = count_ff + CW'(1);
               if (count_ff == '0) begin
                  res_cur = SW'(slot_ff);
               end
            end
         end
         CMD_TICK: begin
            if (count_ff >= CW'(2)) begin
               res_switched = 1'b1;
               if (CW'(pos_ff) + CW'(1) == count_ff) begin
                  res_pos = '0;
                  res_cur = h0_ff;
               end else begin
                  res_pos = pos_ff + SW'(1);
                  res_cur = hp1_ff;
               end
            end
         end
         CMD_SLEEP: begin
            if (!removed_ff) begin
               res_status = STATUS_NOT_RUNNING;
            end else begin
               res_count = count_ff - CW'(1);
               if (res_count == '0) begin
                  res_pos = '0;
                  res_cur = '0;
               end else if (rpos_ff < pos_ff) begin
                  res_pos = pos_ff - SW'(1);
               end else if (rpos_ff == pos_ff) begin
                  res_switched = 1'b1;
                  if (CW'(pos_ff) < res_count) begin
                     res_cur = hp1_ff;
                  end else begin
                     res_pos = '0;
                     res_cur = h0_ff;
                  end
               end
            end
         end
         default: begin
            res_status = STATUS_DONE;
         end
      endcase
   end

   assign req_ready = (fsm_ff == FSM_IDLE);
   assign load      = (fsm_ff == FSM_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      fsm_in       = fsm_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      slot_ok_in   = slot_ok_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      grant_in     = grant_ff;
      hit_state_in = hit_state_ff;
      removed_in   = removed_ff;
      rpos_in      = rpos_ff;
      hp_in        = hp_ff;
      hp1_in       = hp1_ff;
      h0_in        = h0_ff;

      case (fsm_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               fsm_in       = FSM_SCAN;
               idx_in       = '0;
               cmd_in       = cmd_type'(req_command);
               slot_in      = req_task_slot;
               slot_ok_in   = (int'(req_task_slot) < SLOT_COUNT);
               found_in     = 1'b0;
               removed_in   = 1'b0;
               hit_state_in = SS_FREE;
            end
         end
         FSM_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               fsm_in = FSM_DONE;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
            if (alloc_hit) begin
               found_in = 1'b1;
               grant_in = idx_ff;
            end
            if (slot_hit) begin
               hit_state_in = st_q[0];
            end
            if (list_hit) begin
               removed_in = 1'b1;
               rpos_in    = idx_ff;
            end
            if (idx_ff == pos_ff) begin
               hp_in = ls_q[0];
            end
            if (idx_cw == CW'(pos_ff) + CW'(1)) begin
               hp1_in = ls_q[0];
            end
            if (idx_ff == '0) begin
               h0_in = ls_q[0];
            end
         end
         FSM_DONE: begin
            if (load) begin
               fsm_in   = FSM_IDLE;
               count_in = res_count;
               pos_in   = res_pos;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase

      rsp_valid_in    = load || (rsp_valid_ff && !rsp_ready);
      rsp_status_in   = load ? res_status : rsp_status_ff;
      rsp_granted_in  = load ? SLOT_W'(res_granted) : rsp_granted_ff;
      rsp_switched_in = load ? res_switched : rsp_switched_ff;
      rsp_current_in  = load ? SLOT_W'(res_cur) : rsp_current_ff;
      rsp_count_in    = load ? COUNT_W'(res_count) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         count_ff     <= CW'(1);
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      cmd_ff          <= cmd_in;
      slot_ff         <= slot_in;
      slot_ok_ff      <= slot_ok_in;
      found_ff        <= found_in;
      grant_ff        <= grant_in;
      hit_state_ff    <= hit_state_in;
      removed_ff      <= removed_in;
      rpos_ff         <= rpos_in;
      hp_ff           <= hp_in;
      hp1_ff          <= hp1_in;
      h0_ff           <= h0_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_current_ff  <= rsp_current_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_slot  = rsp_granted_ff;
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_current_slot  = rsp_current_ff;
   assign rsp_running_count = rsp_count_ff;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the round-robin task scheduler. A scoreboard class keeps
// its own copy of slot states, run list and position; random and directed commands are
// checked item by item. Depends on rrts_pkg and round_robin_task_scheduler.
`timescale 1ns / 1ps

module tb;
   import rrts_pkg::*;

   localparam int SLOTS = DEFAULT_SLOT_COUNT;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      status_type          status;
      logic [SLOT_W-1:0]   granted;
      logic                switched;
      logic [SLOT_W-1:0]   current;
      logic [COUNT_W-1:0]  count;
   } sched_outcome_type;

   class sched_scoreboard;
      slot_state_type     slot_state [SLOTS];
      logic [SLOT_W-1:0]  run_list [SLOTS];
      int                 run_count;
      int                 current_pos;
      sched_outcome_type  pending_outcomes [$];
      int                 error_count;
      int                 results_checked;
      int                 cmd_seen [4];
      int                 status_seen [4];
      int                 switch_count;
      int                 peak_running;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_state[i] = SS_FREE;
            run_list[i] = '0;
         end
         slot_state[0] = SS_RUN;
         run_count = 1;
         current_pos = 0;
         peak_running = 1;
      endfunction

      function logic [SLOT_W-1:0] current_task();
         if (run_count == 0 || current_pos >= run_count)
            return '0;
         return run_list[current_pos];
      endfunction

      function sched_outcome_type apply_command(cmd_type cmd, logic [SLOT_W-1:0] slot);
         sched_outcome_type o;
         bit                found;
         bit                was_current;
         int                pos;
         o.status = STATUS_DONE;
         o.granted = '0;
         o.switched = 1'b0;
         found = 0;
         case (cmd)
            CMD_ALLOC: begin
               o.status = STATUS_NO_FREE;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found && slot_state[i] == SS_FREE) begin
                     slot_state[i] = SS_ALLOC;
                     o.granted = i[SLOT_W-1:0];
                     o.status = STATUS_DONE;
                     found = 1;
                  end
               end
            end
            CMD_RUN: begin
               if (slot_state[slot] == SS_RUN) begin
                  o.status = STATUS_ALREADY;
               end else if (run_count < SLOTS) begin
                  slot_state[slot] = SS_RUN;
                  run_list[run_count] = slot;
                  run_count++;
               end
            end
            CMD_TICK: begin
               if (run_count >= 2) begin
                  current_pos = (current_pos + 1) % run_count;
                  o.switched = 1'b1;
               end
            end
            default: begin
               if (slot_state[slot] != SS_RUN) begin
                  o.status = STATUS_NOT_RUNNING;
               end else begin
                  was_current = (run_count > 0 && current_task() == slot);
                  pos = run_count;
                  for (int i = 0; i < run_count; i++) begin
                     if (!found && run_list[i] == slot) begin
                        pos = i;
                        found = 1;
                     end
                  end
                  if (pos < run_count) begin
                     run_count--;
                     if (pos < current_pos)
                        current_pos--;
                     for (int i = pos; i < run_count; i++)
                        run_list[i] = run_list[i + 1];
                  end
                  slot_state[slot] = SS_ALLOC;
                  if (current_pos >= run_count)
                     current_pos = 0;
                  if (was_current && run_count > 0)
                     o.switched = 1'b1;
               end
            end
         endcase
         o.current = current_task();
         o.count = run_count[COUNT_W-1:0];
         return o;
      endfunction

      function void note_command(cmd_type cmd, logic [SLOT_W-1:0] slot);
         sched_outcome_type o;
         o = apply_command(cmd, slot);
         pending_outcomes.push_back(o);
         cmd_seen[cmd]++;
         status_seen[o.status]++;
         if (o.switched)
            switch_count++;
         if (run_count > peak_running)
            peak_running = run_count;
      endfunction

      task report_mismatch(string msg);
         error_count++;
         if (error_count <= 40)
            $display("tb: mismatch at %0t: %s", $time, msg);
      endtask

      task check_outcome(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] granted,
                         logic switched, logic [SLOT_W-1:0] current,
                         logic [COUNT_W-1:0] count);
         sched_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result arrived with no command outstanding");
            return;
         end
         want = pending_outcomes.pop_front();
         results_checked++;
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
         if (granted !== want.granted)
            report_mismatch($sformatf("granted_slot %0d, expected %0d", granted, want.granted));
         if (switched !== want.switched)
            report_mismatch($sformatf("switched %0d, expected %0d", switched, want.switched));
         if (current !== want.current)
            report_mismatch($sformatf("current_slot %0d, expected %0d", current, want.current));
         if (count !== want.count)
            report_mismatch($sformatf("running_count %0d, expected %0d", count, want.count));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command = CMD_ALLOC;
   logic [SLOT_W-1:0]   req_task_slot = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_granted_slot;
   logic                rsp_switched;
   logic [SLOT_W-1:0]   rsp_current_slot;
   logic [COUNT_W-1:0]  rsp_running_count;

   sched_scoreboard sched = new();
   bit  sender_gaps_on = 0;
   bit  receiver_stalls_on = 0;
   int  long_holds_asked = 0;
   int  long_holds_done = 0;

   round_robin_task_scheduler uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_task_slot(req_task_slot),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_granted_slot(rsp_granted_slot),
      .rsp_switched(rsp_switched),
      .rsp_current_slot(rsp_current_slot),
      .rsp_running_count(rsp_running_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task send_command(input cmd_type cmd, input logic [SLOT_W-1:0] slot);
      int gap;
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_task_slot <= slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sched.note_command(cmd, slot);
   endtask

   task send_random_command(input int mode);
      int                r;
      cmd_type           cmd;
      logic [SLOT_W-1:0] slot;
      r = $urandom_range(0, 99);
      case (mode)
         0: cmd = (r < 25) ? CMD_ALLOC : (r < 65) ? CMD_RUN : (r < 85) ? CMD_TICK : CMD_SLEEP;
         1: cmd = (r < 10) ? CMD_ALLOC : (r < 25) ? CMD_RUN : (r < 50) ? CMD_TICK : CMD_SLEEP;
         default: cmd = (r < 25) ? CMD_ALLOC : (r < 50) ? CMD_RUN : (r < 75) ? CMD_TICK : CMD_SLEEP;
      endcase
      slot = $urandom_range(0, SLOTS - 1);
      if (cmd == CMD_SLEEP && sched.run_count > 0 && $urandom_range(0, 3) != 0)
         slot = sched.run_list[$urandom_range(0, sched.run_count - 1)];
      send_command(cmd, slot);
   endtask

   // Result side: checks each accepted result and stalls in bursts.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sched.check_outcome(rsp_status, rsp_granted_slot, rsp_switched,
                                rsp_current_slot, rsp_running_count);
         if (long_holds_done != long_holds_asked) begin
            long_holds_done++;
            hold = LONG_HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb: timeout after %0d cycles without progress", quiet);
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed commands around the corner cases of the run list.
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_RUN, 5'd0);
      send_command(CMD_SLEEP, 5'd7);
      send_command(CMD_ALLOC, 5'd31);
      send_command(CMD_ALLOC, 5'd0);
      send_command(CMD_SLEEP, 5'd1);
      send_command(CMD_RUN, 5'd1);
      send_command(CMD_RUN, 5'd31);
      send_command(CMD_RUN, 5'd2);
      send_command(CMD_TICK, 5'd31);
      send_command(CMD_TICK, 5'd0);
      while (sched.current_pos != sched.run_count - 1)
         send_command(CMD_TICK, 5'd0);
      send_command(CMD_SLEEP, sched.current_task());
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_SLEEP, sched.current_task());
      while (sched.run_count > 0)
         send_command(CMD_SLEEP, sched.run_list[0]);
      send_command(CMD_TICK, 5'd0);
      send_command(CMD_SLEEP, 5'd0);
      send_command(CMD_RUN, 5'd0);
      send_command(CMD_ALLOC, 5'd31);

      // Random blocks each pick filling, draining or mixed traffic at random.
      for (int blk = 0; blk < 28; blk++) begin
         int mode;
         mode = $urandom_range(0, 2);
         sender_gaps_on = (blk < 25) && ($urandom_range(0, 9) < 7);
         receiver_stalls_on = (blk < 25) && ($urandom_range(0, 9) < 7);
         if (blk == 8)
            long_holds_asked++;
         for (int k = 0; k < 50; k++)
            send_random_command(mode);
      end

      req_valid <= 1'b0;
      while (sched.pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d commands (alloc %0d, run %0d, tick %0d, sleep %0d),",
               sched.cmd_seen[0] + sched.cmd_seen[1] + sched.cmd_seen[2] + sched.cmd_seen[3],
               sched.cmd_seen[CMD_ALLOC], sched.cmd_seen[CMD_RUN], sched.cmd_seen[CMD_TICK],
               sched.cmd_seen[CMD_SLEEP]);
      $display("summary: %0d results checked, done/no-free/already/not-running %0d/%0d/%0d/%0d,",
               sched.results_checked,
               sched.status_seen[STATUS_DONE], sched.status_seen[STATUS_NO_FREE],
               sched.status_seen[STATUS_ALREADY], sched.status_seen[STATUS_NOT_RUNNING]);
      $display("summary: %0d switches, peak %0d running",
               sched.switch_count, sched.peak_running);
      if (sched.error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/rrts_pkg.sv
rtl/core/rrts_cell.sv
rtl/core/round_robin_task_scheduler.sv
sim/tb.sv
